// ===== rtl/matrix_multiply_assert.svh =====
// ---------------------------------------------------------------------------
// Matrix multiply assertion macros
// Shared clocking and reset wrappers for concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Property checked on every rising clk edge outside reset
`define MM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define MM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/mm_pkg.sv =====
// ---------------------------------------------------------------------------
// mm_pkg
// Types, codes and helpers shared by the matrix multiply modules.
// ---------------------------------------------------------------------------
package mm_pkg;

  // Default largest matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // Field widths fixed by the stream format
  localparam int IDX_W = 3;
  localparam int VAL_W = 32;
  localparam int DIM_W = 4;
  localparam int REG_IDX_W = 2;

  // Input item kinds (carried on s_tuser)
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Commands from controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    logic             rd_en;
    logic [IDX_W-1:0] rd_i;
    logic [IDX_W-1:0] rd_j;
    logic [IDX_W-1:0] rd_k;
    logic             clear;
    logic             out_load;
    logic             out_err;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             out_last;
  } mm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mm_status_t;

  // Dimension actually used: zero counts as one, large values clamp
  function automatic logic [DIM_W-1:0] used_dim(logic [DIM_W-1:0] r,
                                                logic [DIM_W-1:0] max_d);
    logic [DIM_W-1:0] d;
    d = r;
    if (r == '0) d = 4'd1;
    else if (r > max_d) d = max_d;
    return d;
  endfunction

endpackage

// ===== rtl/mm_ram.sv =====
// ---------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mm_ctrl.sv =====
// ---------------------------------------------------------------------------
// mm_ctrl
// Controller: configuration registers, item decode and the run sequencer
// that walks rows, columns and the inner sum index.
// ---------------------------------------------------------------------------
module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [mm_pkg::IDX_W-1:0]       in_row,
  input  logic [mm_pkg::IDX_W-1:0]       in_col,
  input  logic                           cfg_we,
  input  logic [mm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]       cfg_data,
  input  mm_pkg::mm_status_t             status,
  output mm_pkg::mm_cmd_t                cmd
);

  localparam logic [mm_pkg::DIM_W-1:0] MAX_D = mm_pkg::DIM_W'(MAX_DIM);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WAIT = 5'b00100,
    S_EMIT = 5'b01000,
    S_ERR  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [mm_pkg::DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [mm_pkg::DIM_W-1:0] m, n, p, m_next, n_next, p_next;
  logic [mm_pkg::IDX_W-1:0] i, j, k, i_next, j_next, k_next;
  logic [mm_pkg::DIM_W-1:0] used_m, used_n, used_br, used_p;
  logic                     accept, in_range, k_last, j_last, i_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= mm_pkg::DIM_RESET;
      a_cols <= mm_pkg::DIM_RESET;
      b_rows <= mm_pkg::DIM_RESET;
      b_cols <= mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mm_pkg::REG_A_ROWS: a_rows <= cfg_data;
        mm_pkg::REG_A_COLS: a_cols <= cfg_data;
        mm_pkg::REG_B_ROWS: b_rows <= cfg_data;
        mm_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign used_m  = mm_pkg::used_dim(a_rows, MAX_D);
  assign used_n  = mm_pkg::used_dim(a_cols, MAX_D);
  assign used_br = mm_pkg::used_dim(b_rows, MAX_D);
  assign used_p  = mm_pkg::used_dim(b_cols, MAX_D);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_row} < MAX_D) && ({1'b0, in_col} < MAX_D);

  assign k_last = ({1'b0, k} == n - 4'd1);
  assign j_last = ({1'b0, j} == p - 4'd1);
  assign i_last = ({1'b0, i} == m - 4'd1);

  // Next state and commands
  always_comb begin
    state_next   = state;
    m_next       = m;
    n_next       = n;
    p_next       = p;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    cmd          = '0;
    cmd.wr_row   = in_row;
    cmd.wr_col   = in_col;
    cmd.rd_i     = i;
    cmd.rd_j     = j;
    cmd.rd_k     = k;
    cmd.out_row  = i;
    cmd.out_col  = j;
    cmd.out_last = i_last && j_last;
    unique case (state)
      S_IDLE: begin
        cmd.clear = 1'b1;
        if (accept) begin
          case (mm_pkg::mode_t'(in_mode))
            mm_pkg::MODE_LOAD_A: cmd.wr_a = in_range;
            mm_pkg::MODE_LOAD_B: cmd.wr_b = in_range;
            mm_pkg::MODE_COMPUTE: begin
              m_next = used_m;
              n_next = used_n;
              p_next = used_p;
              i_next = '0;
              j_next = '0;
              k_next = '0;
              state_next = (used_n != used_br) ? S_ERR : S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (k_last) begin
          k_next     = '0;
          state_next = S_WAIT;
        end else begin
          k_next = k + 3'd1;
        end
      end
      S_WAIT: begin
        if (!status.pipe_busy) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          if (i_last && j_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
            if (j_last) begin
              j_next = '0;
              i_next = i + 3'd1;
            end else begin
              j_next = j + 3'd1;
            end
          end
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_err  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m     <= '0;
      n     <= '0;
      p     <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      m     <= m_next;
      n     <= n_next;
      p     <= p_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

endmodule

// ===== rtl/mm_datapath.sv =====
// ---------------------------------------------------------------------------
// mm_datapath
// Element stores, multiply-accumulate pipeline, scaling with saturation and
// the output register.
// ---------------------------------------------------------------------------
`include "matrix_multiply_assert.svh"

module mm_datapath #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mm_pkg::mm_cmd_t            cmd,
  output mm_pkg::mm_status_t         status,
  input  logic [mm_pkg::VAL_W-1:0]   wr_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mm_pkg::IDX_W-1:0]   out_row,
  output logic [mm_pkg::IDX_W-1:0]   out_col,
  output logic [mm_pkg::VAL_W-1:0]   out_value,
  output logic                       out_last,
  output logic                       out_err
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * mm_pkg::VAL_W;
  localparam int ACC_W = PW + $clog2(MAX_DIM);
  localparam int SH_W  = ACC_W - 16;

  logic [AW-1:0]                   wr_addr, a_addr, b_addr;
  logic [mm_pkg::VAL_W-1:0]        a_rd, b_rd;
  logic                            v1, v2;
  logic signed [PW-1:0]            prod;
  logic signed [ACC_W-1:0]         acc;
  logic signed [SH_W-1:0]          shr;
  logic [SH_W-32:0]                shr_hi;
  logic [mm_pkg::VAL_W-1:0]        sat;

  // Store addresses, row-major
  assign wr_addr = AW'(cmd.wr_row * MAX_DIM + cmd.wr_col);
  assign a_addr  = AW'(cmd.rd_i * MAX_DIM + cmd.rd_k);
  assign b_addr  = AW'(cmd.rd_k * MAX_DIM + cmd.rd_j);

  mm_ram #(.WIDTH(mm_pkg::VAL_W), .DEPTH(DEPTH)) a_ram (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wr_value),
    .re    (cmd.rd_en),
    .raddr (a_addr),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(mm_pkg::VAL_W), .DEPTH(DEPTH)) b_ram (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wr_value),
    .re    (cmd.rd_en),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  // Pipeline valid bits: read data, then product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (v1) prod <= $signed(a_rd) * $signed(b_rd);
  end

  // Full-width accumulator
  always_ff @(posedge clk) begin
    if (cmd.clear) acc <= '0;
    else if (v2) acc <= acc + ACC_W'(prod);
  end

  // Floor shift by 16, then saturate to 32 bits
  assign shr    = acc[ACC_W-1:16];
  assign shr_hi = shr[SH_W-1:31];
  always_comb begin
    if ((&shr_hi) || !(|shr_hi)) sat = shr[31:0];
    else if (shr[SH_W-1]) sat = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
    else sat = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
  end

  assign status.pipe_busy = v1 || v2;
  assign status.out_free  = !out_valid || out_ready;

  // Output register: holds a result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_err   <= cmd.out_err;
      out_row   <= cmd.out_err ? '0 : cmd.out_row;
      out_col   <= cmd.out_err ? '0 : cmd.out_col;
      out_value <= cmd.out_err ? '0 : sat;
      out_last  <= cmd.out_err || cmd.out_last;
    end
  end

  // A new accumulation never starts while a product is still arriving
  `MM_NEVER(a_clear_vs_prod, cmd.clear && v2, "accumulator cleared with a product in flight")
  // A waiting result is never overwritten
  `MM_NEVER(a_no_overwrite, cmd.out_load && out_valid && !out_ready, "output register overwritten")
  // An error result is always the last of its run
  `MM_ASSERT(a_err_last, out_valid && out_err |-> out_last, "error result without last flag")

endmodule

// ===== rtl/matrix_multiply.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply
// Q16.16 matrix multiply: loads elements of A and B into two stores and
// streams out A*B in row-major order on a compute item.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  tuser: mode; tdata: row, col, value
// m_*      out  m_tvalid/m_tready  tuser: size error; tlast: last of run;
//                                  tdata: row, col, value
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data
//
// Loads can follow back to back.
// A compute makes one store read per inner term of each product element
// through the single MAC, plus a pipeline drain per element.
// A size mismatch gives one error result.
// Reset clears control and sets all dimensions to 8; stores are not cleared.
// A stalled output holds the run at its next result; loads are taken while
// the final result still waits for its transfer.
// ---------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // elem_row, elem_col, elem_value
  input  logic [1:0]                     s_tuser,   // mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // out_row, out_col, out_value
  output logic                           m_tlast,
  output logic                           m_tuser,   // size_error
  input  logic                           cfg_we,
  input  logic [mm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]       cfg_data
);

  mm_pkg::mm_cmd_t          cmd;
  mm_pkg::mm_status_t       status;
  logic [mm_pkg::IDX_W-1:0] out_row, out_col;
  logic [mm_pkg::VAL_W-1:0] out_value;

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_row    (s_tdata[2:0]),
    .in_col    (s_tdata[5:3]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .wr_value  (s_tdata[37:6]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

  // Pack result fields, lowest field first
  assign m_tdata = {2'b00, out_value, out_col, out_row};

endmodule

// ===== tb/matrix_multiply_test.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply_test
// Self-checking bench for the Q16.16 matrix multiply. Elements of A and B are
// loaded over the input stream, products are requested with compute items, and
// every output transfer is checked against a local model of both stores and
// the dimension registers. Covers reset dimensions, clamped dimensions, size
// mismatch, saturation, floor rounding, ignored items, output backpressure
// and random traffic with random gaps on both streams.
// ---------------------------------------------------------------------------
module matrix_multiply_test;

  localparam int MAX_DIM = 8;
  localparam int RANDOM_ITEMS = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_GAP = 13;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [67:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [67:0] SAT_LO = -SAT_HI - 68'sd1;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
    logic        err;
  } product_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;     // elem_row, elem_col, elem_value
  logic [1:0]  s_tuser = '0;     // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // out_row, out_col, out_value
  logic        m_tlast;
  logic        m_tuser;          // size_error
  logic        cfg_we = 1'b0;
  logic [mm_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [mm_pkg::DIM_W-1:0]     cfg_data = '0;

  // Local copy of block state
  logic signed [31:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [31:0] b_mem [MAX_DIM*MAX_DIM];
  bit                 a_written [MAX_DIM*MAX_DIM];
  bit                 b_written [MAX_DIM*MAX_DIM];
  logic [3:0]         a_rows_q = 4'd8;
  logic [3:0]         a_cols_q = 4'd8;
  logic [3:0]         b_rows_q = 4'd8;
  logic [3:0]         b_cols_q = 4'd8;

  product_t pending_products [$];
  int       fail_count = 0;
  int       item_count = 0;
  int       cycle_count = 0;
  bit       gaps_on = 1'b0;
  int       hold_len = 0;

  matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Zero counts as one, oversize clamps to the store size
  function automatic int effective_dim(logic [3:0] r);
    if (r == 4'd0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // Update local state for one accepted item and queue the products it causes
  function automatic void predict_item(logic [1:0] mode, logic [2:0] row,
                                       logic [2:0] col, logic [31:0] value);
    int m, n, kb, p;
    logic signed [63:0] prod;
    logic signed [67:0] acc;
    product_t r;
    case (mode)
      mm_pkg::MODE_LOAD_A: begin
        a_mem[{row, col}] = value;
        a_written[{row, col}] = 1'b1;
      end
      mm_pkg::MODE_LOAD_B: begin
        b_mem[{row, col}] = value;
        b_written[{row, col}] = 1'b1;
      end
      mm_pkg::MODE_COMPUTE: begin
        m = effective_dim(a_rows_q);
        n = effective_dim(a_cols_q);
        kb = effective_dim(b_rows_q);
        p = effective_dim(b_cols_q);
        if (n != kb) begin
          r.row = '0;
          r.col = '0;
          r.value = '0;
          r.last = 1'b1;
          r.err = 1'b1;
          pending_products.push_back(r);
        end else begin
          for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
              acc = '0;
              for (int k = 0; k < n; k++) begin
                prod = a_mem[i*MAX_DIM+k] * b_mem[k*MAX_DIM+j];
                acc = acc + prod;
              end
              // floor shift, then clamp to 32 bits
              acc = acc >>> 16;
              if (acc > SAT_HI) acc = SAT_HI;
              if (acc < SAT_LO) acc = SAT_LO;
              r.row = i[2:0];
              r.col = j[2:0];
              r.value = acc[31:0];
              r.last = (i == m - 1) && (j == p - 1);
              r.err = 1'b0;
              pending_products.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Output side: compare each transfer with the oldest expected product
  always @(posedge clk) begin
    product_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_products.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %0d",
               m_tdata[2:0], m_tdata[5:3], $signed(m_tdata[37:6]));
        fail_count++;
      end else begin
        want = pending_products.pop_front();
        check_field("out_row", longint'(want.row), longint'(m_tdata[2:0]));
        check_field("out_col", longint'(want.col), longint'(m_tdata[5:3]));
        check_field("out_value", longint'($signed(want.value)),
                    longint'($signed(m_tdata[37:6])));
        check_field("last_of_run", longint'(want.last), longint'(m_tlast));
        check_field("size_error", longint'(want.err), longint'(m_tuser));
      end
    end
  end

  // Output ready: random stall per transfer, plus long holds on request
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && hold_len == 0) @(posedge clk);
    end
  end

  // Offer one item and wait for its transfer
  task automatic send_item(input logic [1:0] mode, input logic [2:0] row,
                           input logic [2:0] col, input logic [31:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {2'b00, value, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(mode, row, col, value);
    if (mode != MODE_UNUSED) item_count++;
  endtask

  // Stop offering and let every expected product arrive
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mm_pkg::REG_IDX_W-1:0] index,
                           input logic [mm_pkg::DIM_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      mm_pkg::REG_A_ROWS: a_rows_q = value;
      mm_pkg::REG_A_COLS: a_cols_q = value;
      mm_pkg::REG_B_ROWS: b_rows_q = value;
      mm_pkg::REG_B_COLS: b_cols_q = value;
      default: ;
    endcase
  endtask

  // Only called while the block is idle
  task automatic set_dims(input logic [3:0] ar, input logic [3:0] ac,
                          input logic [3:0] br, input logic [3:0] bc);
    write_reg(mm_pkg::REG_A_ROWS, ar);
    write_reg(mm_pkg::REG_A_COLS, ac);
    write_reg(mm_pkg::REG_B_ROWS, br);
    write_reg(mm_pkg::REG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF);
      3: return -$urandom_range(0, 32'h3_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Load any operand the next product would read but was never written,
  // then request the product
  task automatic run_product();
    int m, n, kb, p;
    m = effective_dim(a_rows_q);
    n = effective_dim(a_cols_q);
    kb = effective_dim(b_rows_q);
    p = effective_dim(b_cols_q);
    if (n == kb) begin
      for (int i = 0; i < m; i++)
        for (int k = 0; k < n; k++)
          if (!a_written[i*MAX_DIM+k])
            send_item(mm_pkg::MODE_LOAD_A, 3'(i), 3'(k), rand_value());
      for (int k = 0; k < n; k++)
        for (int j = 0; j < p; j++)
          if (!b_written[k*MAX_DIM+j])
            send_item(mm_pkg::MODE_LOAD_B, 3'(k), 3'(j), rand_value());
    end
    send_item(mm_pkg::MODE_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
  endtask

  // Full 8x8 product with the dimensions left by reset
  task automatic test_reset_dims();
    gaps_on = 1'b0;
    run_product();
    wait_idle();
  endtask

  // Extreme values, rounding, ignored items, clamped dims and size errors
  task automatic test_directed();
    set_dims(4'd2, 4'd2, 4'd2, 4'd2);
    send_item(mm_pkg::MODE_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(mm_pkg::MODE_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
    send_item(mm_pkg::MODE_LOAD_A, 3'd1, 3'd0, 32'h8000_0000);
    send_item(mm_pkg::MODE_LOAD_A, 3'd1, 3'd1, 32'hFFFF_FFFF);
    send_item(mm_pkg::MODE_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(mm_pkg::MODE_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
    send_item(mm_pkg::MODE_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
    send_item(mm_pkg::MODE_LOAD_B, 3'd1, 3'd1, 32'h0001_0000);
    send_item(mm_pkg::MODE_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    // unused mode must leave the stores alone
    send_item(MODE_UNUSED, 3'd0, 3'd0, 32'h0000_0000);
    send_item(MODE_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(mm_pkg::MODE_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    // far corner of both stores
    send_item(mm_pkg::MODE_LOAD_A, 3'd7, 3'd7, 32'h0001_8000);
    send_item(mm_pkg::MODE_LOAD_B, 3'd7, 3'd7, 32'hFFFE_8000);
    wait_idle();
    // 15 clamps to 8, 0 counts as 1, 9 clamps to 8
    set_dims(4'd15, 4'd0, 4'd1, 4'd9);
    run_product();
    wait_idle();
    // both inner dims clamp to 8 and so agree
    set_dims(4'd1, 4'd9, 4'd12, 4'd1);
    run_product();
    wait_idle();
    // inner dims disagree
    set_dims(4'd3, 4'd3, 4'd2, 4'd3);
    run_product();
    wait_idle();
    set_dims(4'd8, 4'd5, 4'd4, 4'd6);
    run_product();
    wait_idle();
    // 1x1 product from all-zero registers
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    run_product();
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering work
  task automatic test_backpressure();
    set_dims(4'd8, 4'd8, 4'd8, 4'd8);
    gaps_on = 1'b0;
    hold_len = 400;
    run_product();
    for (int t = 0; t < 20; t++)
      send_item(2'($urandom_range(0, 1)), 3'($urandom()), 3'($urandom()), rand_value());
    run_product();
    wait_idle();
  endtask

  // Random phases: new dims each phase, mixed loads, products and noise
  task automatic test_random_items();
    int first;
    int pick;
    logic [3:0] ac;
    first = item_count;
    while (item_count - first < RANDOM_ITEMS) begin
      wait_idle();
      ac = rand_dim();
      set_dims(rand_dim(), ac, ($urandom_range(0, 4) == 0) ? rand_dim() : ac, rand_dim());
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(15, 40)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          send_item(2'($urandom_range(0, 1)), 3'($urandom()), 3'($urandom()),
                    rand_value());
        else if (pick < 9)
          run_product();
        else
          send_item(MODE_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
      end
      run_product();
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_dims();
    test_directed();
    test_backpressure();
    test_random_items();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_products.size() != 0) begin
      $error("%0d expected results never arrived", pending_products.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_ctrl.sv
rtl/mm_datapath.sv
rtl/matrix_multiply.sv
tb/matrix_multiply_test.sv
